// ===== rtl/bmld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmld_pkg
// Types, constants and elaboration-time log table for the block model
// log-likelihood delta engine.
// ----------------------------------------------------------------------------
package bmld_pkg;

  localparam int MAX_BLOCKS   = 16;
  localparam int BLK_W        = $clog2(MAX_BLOCKS);
  localparam int NB_W         = BLK_W + 1;
  localparam int PROB_BITS    = 10;
  localparam int PROB_ONE     = 1 << PROB_BITS;
  localparam int LN_FRAC_BITS = 12;
  localparam int LN_W         = 16;
  localparam int Q_BITS       = 56;
  localparam int IDX_W        = 7;
  localparam int CNT_W        = 16;
  localparam int ACC_W        = 48;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BLOCKS     = 2'd0,
    CFG_CURRENT_BLOCK  = 2'd1,
    CFG_PROPOSED_BLOCK = 2'd2
  } cfg_reg_e;

  typedef logic signed [LN_W-1:0] ln_t;

  // ln of p and of one minus p for one stored entry
  typedef struct packed {
    ln_t ln_p;
    ln_t ln_q;
  } ln_pair_t;

  typedef ln_t ln_rom_t [PROB_ONE];

  typedef struct packed {
    logic                 mode;
    logic [IDX_W-1:0]     entry_index;
    logic [PROB_BITS-1:0] entry_prob;
    logic [CNT_W-1:0]     wins;
    logic [CNT_W-1:0]     losses;
    logic [BLK_W-1:0]     opponent_block;
    logic                 last_opponent;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] delta;
    logic                    saturated;
  } out_t;

  function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[Q_BITS+63:Q_BITS];
  endfunction

  function automatic logic [63:0] q_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = num;
    for (int i = 0; i < Q_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] u_div(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2*atanh(num/den) in Q56
  function automatic logic [63:0] ln_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    t    = q_div(num, den);
    t2   = q_mul(t, t);
    term = t;
    sum  = '0;
    for (int j = 1; j < 200; j += 2) begin
      if (term != 64'd0) begin
        sum  = sum + u_div(term, 64'(j));
        term = q_mul(term, t2);
      end
    end
    return sum << 1;
  endfunction

  function automatic ln_t ln_entry(input int k);
    logic [63:0] ln2;
    logic [63:0] half;
    logic [63:0] pw;
    logic [63:0] lm;
    logic [63:0] neg;
    logic [63:0] mag;
    int          e;
    if (k < 1) begin
      return '0;
    end
    ln2  = ln_ratio(64'd1, 64'd3);
    half = 64'd1 << (Q_BITS - LN_FRAC_BITS - 1);
    e    = 0;
    for (int b = 1; b <= PROB_BITS; b++) begin
      if ((k >> b) != 0) begin
        e = b;
      end
    end
    pw  = 64'd1 << e;
    lm  = (64'(k) == pw) ? 64'd0 : ln_ratio(64'(k) - pw, 64'(k) + pw);
    neg = 64'(PROB_BITS - e) * ln2 - lm;
    mag = (neg + half) >> (Q_BITS - LN_FRAC_BITS);
    return LN_W'(64'd0 - mag);
  endfunction

  function automatic ln_rom_t build_ln_rom();
    ln_rom_t r;
    for (int k = 0; k < PROB_ONE; k++) begin
      r[k] = ln_entry(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bmld_ln_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmld_ln_rom
// Dual-read natural log ROM, round(ln(k/2^PROB_BITS)*2^LN_FRAC_BITS),
// registered read data.
// ----------------------------------------------------------------------------
module bmld_ln_rom (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [bmld_pkg::PROB_BITS-1:0] addr_a_i,
  input  logic [bmld_pkg::PROB_BITS-1:0] addr_b_i,
  output bmld_pkg::ln_t                  data_a_o,
  output bmld_pkg::ln_t                  data_b_o
);
  import bmld_pkg::*;

  localparam ln_rom_t LnRom = build_ln_rom();

  ln_t data_a_q;
  ln_t data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= LnRom[addr_a_i];
      data_b_q <= LnRom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule
`default_nettype wire

// ===== rtl/bmld_prob_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmld_prob_table
// Block-pair table of log win and log loss probabilities, one write port,
// two registered read ports.
// ----------------------------------------------------------------------------
module bmld_prob_table #(
  parameter int Depth = 120,
  parameter int AddrW = 7
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  bmld_pkg::ln_pair_t wr_data_i,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_a_i,
  input  logic [AddrW-1:0]   rd_addr_b_i,
  output bmld_pkg::ln_pair_t rd_data_a_o,
  output bmld_pkg::ln_pair_t rd_data_b_o
);
  import bmld_pkg::*;

  ln_pair_t mem_q [Depth];
  ln_pair_t rd_a_q;
  ln_pair_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule
`default_nettype wire

// ===== rtl/block_model_loglik_delta.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_model_loglik_delta
// Log-likelihood change of a pairwise-comparison block model when one node
// moves from its current block to a proposed block.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  in        | in        | in_valid_i / in_stall_o | in_data_i  (bmld_pkg::in_t)
//  out       | out       | out_valid_o / out_stall_i | out_data_o (bmld_pkg::out_t)
//  cfg       | in        | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
//  One transaction per cycle while the output is not stalled. A result for a
//  last-opponent transaction passes, registered at each step, through lookup
//  and ROM read, two multipliers, then the saturating accumulator into the
//  output register. A table load is written from the stage 1 registers and
//  forwarded to a lookup in the same cycle. Reset clears accumulator, flag
//  and valids; the table has no clearing pass. An output stall freezes the
//  pipeline; an input skid register keeps in_stall_o registered.
// ----------------------------------------------------------------------------
module block_model_loglik_delta #(
  parameter int TABLE_ENTRIES = 120
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bmld_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bmld_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bmld_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bmld_pkg::NB_W-1:0]      cfg_wdata_i
);
  import bmld_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PW = CNT_W + LN_W + 2;
  localparam int SW = ACC_W + 2;
  localparam ln_t LnHalf = ln_entry(PROB_ONE / 2);
  localparam logic signed [SW-1:0] AccMax = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [SW-1:0] AccMin = {3'b111, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    SEL_HALF,
    SEL_DIRECT,
    SEL_SWAP
  } lk_sel_e;

  typedef struct packed {
    lk_sel_e       sel;
    logic [AW-1:0] addr;
  } lk_t;

  function automatic lk_t lookup(input logic [BLK_W-1:0] a, input logic [BLK_W-1:0] b,
                                 input logic [NB_W-1:0] n);
    logic [BLK_W-1:0]   row;
    logic [BLK_W-1:0]   col;
    logic signed [7:0]  span;
    logic signed [12:0] tri_p;
    logic signed [12:0] idx;
    lk_t                r;
    row   = (a < b) ? a : b;
    col   = (a < b) ? b : a;
    span  = $signed({2'b00, n, 1'b0}) - 8'sd1 - $signed({4'b0000, row});
    tri_p = $signed({1'b0, row}) * span;
    idx   = (tri_p >>> 1) + $signed({9'd0, col}) - $signed({9'd0, row}) - 13'sd1;
    r.addr = AW'(idx);
    if (a == b || idx[12] || int'(idx) >= TABLE_ENTRIES) begin
      r.sel = SEL_HALF;
    end else if (a > b) begin
      r.sel = SEL_SWAP;
    end else begin
      r.sel = SEL_DIRECT;
    end
    return r;
  endfunction

  function automatic ln_pair_t resolve(input lk_sel_e sel, input ln_pair_t raw);
    ln_pair_t r;
    case (sel)
      SEL_DIRECT: r = raw;
      SEL_SWAP:   r = '{ln_p: raw.ln_q, ln_q: raw.ln_p};
      default:    r = '{ln_p: LnHalf, ln_q: LnHalf};
    endcase
    return r;
  endfunction

  // configuration
  logic [NB_W-1:0]  nb_q;
  logic [BLK_W-1:0] cur_q;
  logic [BLK_W-1:0] prop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q   <= NB_W'(2);
      cur_q  <= '0;
      prop_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_BLOCKS:     nb_q   <= cfg_wdata_i;
        CFG_CURRENT_BLOCK:  cur_q  <= cfg_wdata_i[BLK_W-1:0];
        CFG_PROPOSED_BLOCK: prop_q <= cfg_wdata_i[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // input skid and head
  logic skid_valid_q;
  in_t  skid_q;
  logic hd_valid;
  in_t  hd;
  logic en;
  logic out_valid_q;
  out_t out_q;

  assign en         = ~out_valid_q | ~out_stall_i;
  assign hd_valid   = skid_valid_q | in_valid_i;
  assign hd         = skid_valid_q ? skid_q : in_data_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

  // head decode
  logic [PROB_BITS-1:0] pc;
  logic [PROB_BITS-1:0] pc_inv;
  logic                 hd_wr_ok;
  lk_t                  lk_old;
  lk_t                  lk_new;

  assign pc       = (hd.entry_prob == '0) ? PROB_BITS'(1) : hd.entry_prob;
  assign pc_inv   = PROB_BITS'(PROB_ONE - int'(pc));
  assign hd_wr_ok = int'(hd.entry_index) < TABLE_ENTRIES;
  assign lk_old   = lookup(cur_q, hd.opponent_block, nb_q);
  assign lk_new   = lookup(prop_q, hd.opponent_block, nb_q);

  // stage 1
  logic             s1_valid_q;
  logic             s1_mode_q;
  logic             s1_last_q;
  logic [CNT_W-1:0] s1_wins_q;
  logic [CNT_W-1:0] s1_losses_q;
  lk_sel_e          s1_sel_old_q;
  lk_sel_e          s1_sel_new_q;
  logic             s1_wr_ok_q;
  logic [AW-1:0]    s1_wr_addr_q;
  logic             byp_old_q;
  logic             byp_new_q;
  ln_pair_t         byp_data_q;
  ln_t              rom_p;
  ln_t              rom_q;
  ln_pair_t         wr_data;
  logic             tbl_we;
  ln_pair_t         rd_old;
  ln_pair_t         rd_new;

  assign wr_data = '{ln_p: rom_p, ln_q: rom_q};
  assign tbl_we  = en & s1_valid_q & ~s1_mode_q & s1_wr_ok_q;

  bmld_ln_rom u_ln_rom (
    .clk_i    (clk_i),
    .en_i     (en),
    .addr_a_i (pc),
    .addr_b_i (pc_inv),
    .data_a_o (rom_p),
    .data_b_o (rom_q)
  );

  bmld_prob_table #(
    .Depth (TABLE_ENTRIES),
    .AddrW (AW)
  ) u_prob_table (
    .clk_i       (clk_i),
    .we_i        (tbl_we),
    .wr_addr_i   (s1_wr_addr_q),
    .wr_data_i   (wr_data),
    .rd_en_i     (en),
    .rd_addr_a_i (lk_old.addr),
    .rd_addr_b_i (lk_new.addr),
    .rd_data_a_o (rd_old),
    .rd_data_b_o (rd_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= hd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mode_q    <= hd.mode;
      s1_last_q    <= hd.last_opponent;
      s1_wins_q    <= hd.wins;
      s1_losses_q  <= hd.losses;
      s1_sel_old_q <= lk_old.sel;
      s1_sel_new_q <= lk_new.sel;
      s1_wr_ok_q   <= hd_wr_ok;
      s1_wr_addr_q <= AW'(hd.entry_index);
      byp_old_q    <= tbl_we && (s1_wr_addr_q == lk_old.addr);
      byp_new_q    <= tbl_we && (s1_wr_addr_q == lk_new.addr);
      byp_data_q   <= wr_data;
    end
  end

  ln_pair_t             pr_old;
  ln_pair_t             pr_new;
  logic signed [LN_W:0] dw;
  logic signed [LN_W:0] dl;
  logic signed [PW-1:0] pw;
  logic signed [PW-1:0] pl;

  assign pr_old = resolve(s1_sel_old_q, byp_old_q ? byp_data_q : rd_old);
  assign pr_new = resolve(s1_sel_new_q, byp_new_q ? byp_data_q : rd_new);
  assign dw = $signed({pr_new.ln_p[LN_W-1], pr_new.ln_p})
            - $signed({pr_old.ln_p[LN_W-1], pr_old.ln_p});
  assign dl = $signed({pr_new.ln_q[LN_W-1], pr_new.ln_q})
            - $signed({pr_old.ln_q[LN_W-1], pr_old.ln_q});
  assign pw = $signed({1'b0, s1_wins_q}) * dw;
  assign pl = $signed({1'b0, s1_losses_q}) * dl;

  // stage 2
  logic                 s2_valid_q;
  logic                 s2_last_q;
  logic signed [PW-1:0] s2_pw_q;
  logic signed [PW-1:0] s2_pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q & s1_mode_q;
    end
  end

  // drop a product whose count is zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_last_q <= s1_last_q;
      s2_pw_q   <= (s1_wins_q != '0) ? pw : '0;
      s2_pl_q   <= (s1_losses_q != '0) ? pl : '0;
    end
  end

  // accumulate
  logic signed [ACC_W-1:0] acc_q;
  logic                    sat_q;
  logic signed [SW-1:0]    sum;
  logic                    sat_hi;
  logic                    sat_lo;
  logic signed [ACC_W-1:0] acc_d;
  logic                    sat_d;

  assign sum    = SW'(acc_q) + SW'(s2_pw_q) + SW'(s2_pl_q);
  assign sat_hi = sum > AccMax;
  assign sat_lo = sum < AccMin;
  assign acc_d  = sat_hi ? AccMax[ACC_W-1:0] : (sat_lo ? AccMin[ACC_W-1:0] : sum[ACC_W-1:0]);
  assign sat_d  = sat_q | sat_hi | sat_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (en && s2_valid_q) begin
      if (s2_last_q) begin
        acc_q <= '0;
        sat_q <= 1'b0;
      end else begin
        acc_q <= acc_d;
        sat_q <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q & s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q && s2_last_q) begin
      out_q <= '{delta: acc_d, saturated: sat_d};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_stall_holds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(acc_q) && $stable(sat_q))
    else $error("accumulator moved during output stall");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> int'(s1_wr_addr_q) < TABLE_ENTRIES)
    else $error("table write beyond depth");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s2_valid_q && s2_last_q |=> acc_q == '0 && !sat_q)
    else $error("accumulator not cleared after result");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block model log-likelihood delta engine. A
// probability table is loaded, then opponent transactions are streamed under
// many block settings and compared against a behavioral accumulator. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bmld_pkg::*;

  localparam int     TABLE_SIZE   = 120;
  localparam int     HALF_PROB    = PROB_ONE / 2;
  localparam int     DRAIN_CYCLES = 20;
  localparam int     CYCLE_LIMIT  = 3000000;
  localparam int     RANDOM_ITEMS = 1150;
  localparam longint ACC_HI       = 64'sd140737488355327;
  localparam longint ACC_LO       = -ACC_HI - 64'sd1;

  class loglik_delta_tracker;
    int                   ln_q12[PROB_ONE];
    logic [PROB_BITS-1:0] prob_mem[TABLE_SIZE];
    longint               acc;
    bit                   acc_sat;
    int                   nb;
    int                   cur_blk;
    int                   prop_blk;
    out_t                 pending_deltas[$];
    int                   errors;

    function new();
      ln_q12[0] = 0;
      for (int k = 1; k < PROB_ONE; k++) begin
        ln_q12[k] = -int'($floor(-$ln(real'(k) / real'(PROB_ONE))
                                 * real'(1 << LN_FRAC_BITS) + 0.5));
      end
      foreach (prob_mem[i]) prob_mem[i] = '0;
      acc      = 0;
      acc_sat  = 1'b0;
      nb       = 2;
      cur_blk  = 0;
      prop_blk = 0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [NB_W-1:0] v);
      case (idx)
        CFG_NUM_BLOCKS:     nb = v;
        CFG_CURRENT_BLOCK:  cur_blk = v[BLK_W-1:0];
        CFG_PROPOSED_BLOCK: prop_blk = v[BLK_W-1:0];
        default: ;
      endcase
    endfunction

    // probability that block a beats block b
    function int win_chance(int a, int b);
      int row;
      int col;
      int idx;
      int p;
      if (a == b) return HALF_PROB;
      row = (a < b) ? a : b;
      col = (a < b) ? b : a;
      idx = row * (2 * nb - 1 - row) / 2 + (col - row) - 1;
      if (idx < 0 || idx >= TABLE_SIZE) return HALF_PROB;
      p = prob_mem[idx];
      return (a > b) ? PROB_ONE - p : p;
    endfunction

    function void accept_item(in_t it);
      int     p_old;
      int     p_new;
      longint gain;
      out_t   want;
      if (it.mode == 1'b0) begin
        if (it.entry_index < TABLE_SIZE) begin
          prob_mem[it.entry_index] = (it.entry_prob == '0) ? PROB_BITS'(1) : it.entry_prob;
        end
        return;
      end
      if (it.wins != '0 || it.losses != '0) begin
        p_old = win_chance(cur_blk, it.opponent_block);
        p_new = win_chance(prop_blk, it.opponent_block);
        gain  = longint'(it.wins) * (ln_q12[p_new] - ln_q12[p_old])
              + longint'(it.losses) * (ln_q12[PROB_ONE - p_new] - ln_q12[PROB_ONE - p_old]);
        acc = acc + gain;
        if (acc > ACC_HI) begin
          acc     = ACC_HI;
          acc_sat = 1'b1;
        end
        if (acc < ACC_LO) begin
          acc     = ACC_LO;
          acc_sat = 1'b1;
        end
      end
      if (it.last_opponent) begin
        want.delta     = acc[ACC_W-1:0];
        want.saturated = acc_sat;
        pending_deltas.push_back(want);
        acc     = 0;
        acc_sat = 1'b0;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_deltas.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual delta %0d saturated %0b",
                 $time, got.delta, got.saturated);
        return;
      end
      want = pending_deltas.pop_front();
      if (got.delta !== want.delta) begin
        errors++;
        $display("%0t: delta mismatch, expected %0d, actual %0d",
                 $time, want.delta, got.delta);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
      end
    endfunction

    function int pending();
      return pending_deltas.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  in_t             in_data_i;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_we_i;
  cfg_reg_e        cfg_index_i;
  logic [NB_W-1:0] cfg_wdata_i;

  loglik_delta_tracker tracker = new();
  bit                  quiet = 1'b0;
  int                  cycles = 0;

  block_model_loglik_delta DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 37);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) tracker.accept_item(in_data_i);
      if (out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int rand_count();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic in_t load_item(int idx, int prob, bit last);
    in_t it;
    it.mode           = 1'b0;
    it.entry_index    = IDX_W'(idx);
    it.entry_prob     = PROB_BITS'(prob);
    it.wins           = CNT_W'($urandom);
    it.losses         = CNT_W'($urandom);
    it.opponent_block = BLK_W'($urandom);
    it.last_opponent  = last;
    return it;
  endfunction

  function automatic in_t opp_item(int w, int l, int blk, bit last);
    in_t it;
    it.mode           = 1'b1;
    it.entry_index    = IDX_W'($urandom);
    it.entry_prob     = PROB_BITS'($urandom);
    it.wins           = CNT_W'(w);
    it.losses         = CNT_W'(l);
    it.opponent_block = BLK_W'(blk);
    it.last_opponent  = last;
    return it;
  endfunction

  task automatic send_item(in_t item);
    bit taken;
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(int nblk, int cur, int prop);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_NUM_BLOCKS;
    cfg_wdata_i <= NB_W'(nblk);
    @(posedge clk_i);
    cfg_index_i <= CFG_CURRENT_BLOCK;
    cfg_wdata_i <= NB_W'(cur);
    @(posedge clk_i);
    cfg_index_i <= CFG_PROPOSED_BLOCK;
    cfg_wdata_i <= NB_W'(prop);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(load_item($urandom_range(0, 127), $urandom_range(0, 1023),
                            $urandom_range(0, 1)));
      end else begin
        send_item(opp_item(rand_count(), rand_count(), $urandom_range(0, 15),
                           $urandom_range(0, 7) == 0));
      end
    end
    send_item(opp_item(rand_count(), rand_count(), $urandom_range(0, 15), 1'b1));
  endtask

  initial begin
    int total;
    int ph;
    int len;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_NUM_BLOCKS;
    cfg_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(16, 3, 12);
    for (int k = 0; k < TABLE_SIZE; k++) begin
      send_item(load_item(k, (k == 0) ? 0 : (k == TABLE_SIZE - 1) ? 1023 :
                          $urandom_range(1, 1022), $urandom_range(0, 1)));
    end

    send_item(opp_item(0, 0, 5, 1'b0));
    send_item(opp_item(65535, 65535, 15, 1'b0));
    send_item(opp_item(100, 7, 3, 1'b0));
    send_item(opp_item(9, 300, 12, 1'b1));
    send_item(load_item(127, 555, 1'b0));
    send_item(load_item(2, 0, 1'b1));
    send_item(opp_item(500, 400, 0, 1'b0));
    send_item(load_item(11, 1023, 1'b0));
    send_item(opp_item(20000, 1, 0, 1'b1));
    send_item(opp_item(0, 0, 7, 1'b1));
    send_item(opp_item(65535, 0, 0, 1'b1));
    send_item(opp_item(0, 65535, 15, 1'b1));
    send_item(load_item(120, 1, 1'b1));
    send_item(opp_item(1, 1, 11, 1'b0));
    send_item(opp_item(65535, 65535, 12, 1'b1));

    total = 0;
    ph    = 0;
    while (total < RANDOM_ITEMS) begin
      wait_drained();
      quiet = (ph == 4);
      case (ph % 7)
        0:       set_config(2, $urandom_range(0, 1), $urandom_range(0, 1));
        1:       set_config(16, 0, 15);
        2:       set_config(16, 15, 0);
        3:       set_config(0, $urandom_range(0, 15), $urandom_range(0, 15));
        4:       set_config(31, $urandom_range(0, 15), $urandom_range(0, 15));
        5:       set_config(1, $urandom_range(0, 15), $urandom_range(0, 15));
        default: set_config($urandom_range(2, 16), $urandom_range(0, 15),
                            $urandom_range(0, 15));
      endcase
      len = $urandom_range(40, 120);
      run_phase(len);
      total += len + 1;
      ph++;
    end
    quiet = 1'b0;

    wait_drained();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/bmld_pkg.sv
rtl/bmld_ln_rom.sv
rtl/bmld_prob_table.sv
rtl/block_model_loglik_delta.sv
sim/tb_top.sv
